// File: sv/fpba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared types, codes and helpers of the fit-policy block allocator.
// ----------------------------------------------------------------------------
package fpba_pkg;

    localparam int AMOUNT_W = 20;
    localparam int SIZE_W   = 16;
    localparam int COUNT_W  = 9;
    localparam int KB_W     = AMOUNT_W + 1;
    localparam int CFG_IDX_W = 1;

    localparam logic [KB_W-1:0] KB_CAP = KB_W'(1) << AMOUNT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE_KB = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT   = 1'b1;

    localparam logic [SIZE_W-1:0]  BLOCK_SIZE_RESET  = 16'd4;
    localparam logic [COUNT_W-1:0] BLOCK_COUNT_RESET = 9'd256;

    typedef enum logic [1:0] {
        ACT_FIRST = 2'd0,
        ACT_BEST  = 2'd1,
        ACT_WORST = 2'd2,
        ACT_FREE  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_CLOSE,
        ST_MARK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]          action;
        logic [AMOUNT_W-1:0] amount_kb;
    } req_t;

    typedef struct packed {
        logic               ok;
        logic [7:0]         run_start;
        logic [COUNT_W-1:0] free_count;
    } rsp_t;

    // Adds one block's size to a running kilobyte total that saturates just
    // above the largest amount.
    function automatic logic [KB_W-1:0] sat_add(input logic [KB_W-1:0] acc,
                                                input logic [SIZE_W-1:0] size);
        logic [KB_W-1:0] sum;
        sum = acc + KB_W'(size);
        return (sum > KB_CAP) ? KB_CAP : sum;
    endfunction

endpackage

// File: sv/fit_policy_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_policy_block_allocator
// Bitmap allocator of equal-sized blocks with first, best and worst fit.
// ----------------------------------------------------------------------------
// A request beat on req carries an action and an amount in kilobytes; each
// request gives exactly one beat on rsp with ok, the run start and the number
// of free blocks in the use range. Configuration beats on cfg are always
// taken and set the block size (index 0) and the block count (index 1).
// The bitmap sits in a one-bit RAM. After reset a clearing pass writes
// every block free; req_ready stays low meanwhile. For an allocation, one
// streaming read pass over the RAM picks the run, and a write pass marks it;
// a free clears used blocks during its read pass. One request is in work at
// a time; req_ready rises again once the result sits in the output register.
// If the receiver stalls, the finished result holds and a later result waits
// until the earlier beat is taken.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator #(
    parameter int MAX_BLOCKS = 256
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    output logic                                  req_ready,
    input  fpba_pkg::req_t                        req,
    output logic                                  rsp_valid,
    input  logic                                  rsp_ready,
    output fpba_pkg::rsp_t                        rsp,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [fpba_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [fpba_pkg::SIZE_W-1:0]           cfg_data
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int NW = (CW > fpba_pkg::COUNT_W) ? CW : fpba_pkg::COUNT_W;
    localparam int KB_W = fpba_pkg::KB_W;

    fpba_pkg::state_t state_reg, state_next;

    logic [fpba_pkg::SIZE_W-1:0]   block_size_reg;
    logic [fpba_pkg::COUNT_W-1:0]  block_count_reg;

    logic [1:0]                    action_reg, action_next;
    logic [fpba_pkg::AMOUNT_W-1:0] amount_reg, amount_next;
    logic [CW-1:0]                 addr_reg, addr_next;
    logic                          d_vld_reg, d_vld_next;
    logic [IW-1:0]                 d_idx_reg, d_idx_next;
    logic                          run_open_reg, run_open_next;
    logic [IW-1:0]                 run_s_reg, run_s_next;
    logic [CW-1:0]                 run_len_reg, run_len_next;
    logic [KB_W-1:0]               run_kb_reg, run_kb_next;
    logic                          found_reg, found_next;
    logic [IW-1:0]                 pick_reg, pick_next;
    logic [CW-1:0]                 pick_len_reg, pick_len_next;
    logic                          pick_adeq_reg, pick_adeq_next;
    logic [CW-1:0]                 free_cnt_reg, free_cnt_next;
    logic [KB_W-1:0]               acc_reg, acc_next;
    fpba_pkg::rsp_t                rsp_reg, rsp_next;
    logic                          rsp_valid_reg, rsp_valid_next;

    logic [CW-1:0]  use_n;
    logic [NW-1:0]  count_ext;
    logic           issue;
    logic           ram_we;
    logic [IW-1:0]  ram_waddr;
    logic           ram_wdata;
    logic           ram_rdata;
    logic           cand_adeq;
    logic           cand_take;
    logic           scan_end;
    logic           mark_go;
    logic           is_free;
    logic           rsp_load;
    logic           done_ok;
    logic [IW+7:0]  start_ext;
    logic [CW+8:0]  free_ext;

    fpba_ram #(
        .WIDTH(1),
        .DEPTH(MAX_BLOCKS)
    ) u_bitmap (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (issue),
        .raddr(addr_reg[IW-1:0]),
        .rdata(ram_rdata)
    );

    assign count_ext = NW'(block_count_reg);
    assign use_n     = (count_ext > NW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(count_ext);

    assign is_free   = (action_reg == fpba_pkg::ACT_FREE);
    assign issue     = (state_reg == fpba_pkg::ST_SCAN) && (addr_reg < use_n);
    assign scan_end  = !d_vld_reg && (addr_reg >= use_n);
    assign mark_go   = found_reg && pick_adeq_reg && (block_size_reg != '0)
                       && (acc_reg < KB_W'(amount_reg)) && (addr_reg < pick_len_reg);
    assign rsp_load  = (state_reg == fpba_pkg::ST_DONE) && (!rsp_valid_reg || rsp_ready);
    assign cand_adeq = (run_kb_reg >= KB_W'(amount_reg));

    assign req_ready = (state_reg == fpba_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        case (action_reg)
            fpba_pkg::ACT_FIRST: cand_take = !found_reg && cand_adeq;
            fpba_pkg::ACT_BEST:  cand_take = cand_adeq
                                             && (!found_reg || run_len_reg < pick_len_reg);
            fpba_pkg::ACT_WORST: cand_take = !found_reg || run_len_reg > pick_len_reg;
            default:             cand_take = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fpba_pkg::ST_CLEAR:
            begin
                if (addr_reg == CW'(MAX_BLOCKS - 1))
                begin
                    state_next = fpba_pkg::ST_IDLE;
                end
            end
            fpba_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = fpba_pkg::ST_SCAN;
                end
            end
            fpba_pkg::ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = is_free ? fpba_pkg::ST_DONE : fpba_pkg::ST_CLOSE;
                end
            end
            fpba_pkg::ST_CLOSE:
            begin
                state_next = fpba_pkg::ST_MARK;
            end
            fpba_pkg::ST_MARK:
            begin
                if (!mark_go)
                begin
                    state_next = fpba_pkg::ST_DONE;
                end
            end
            fpba_pkg::ST_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = fpba_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fpba_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        action_next    = action_reg;
        amount_next    = amount_reg;
        addr_next      = addr_reg;
        d_vld_next     = d_vld_reg;
        d_idx_next     = d_idx_reg;
        run_open_next  = run_open_reg;
        run_s_next     = run_s_reg;
        run_len_next   = run_len_reg;
        run_kb_next    = run_kb_reg;
        found_next     = found_reg;
        pick_next      = pick_reg;
        pick_len_next  = pick_len_reg;
        pick_adeq_next = pick_adeq_reg;
        free_cnt_next  = free_cnt_reg;
        acc_next       = acc_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        ram_we         = 1'b0;
        ram_waddr      = d_idx_reg;
        ram_wdata      = 1'b0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        done_ok   = is_free ? (acc_reg >= KB_W'(amount_reg)) : (found_reg && pick_adeq_reg);
        start_ext = {8'b0, pick_reg};
        free_ext  = {9'b0, free_cnt_reg};

        case (state_reg)
            fpba_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_reg[IW-1:0];
                ram_wdata = 1'b0;
                addr_next = addr_reg + CW'(1);
            end
            fpba_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    action_next   = req.action;
                    amount_next   = req.amount_kb;
                    addr_next     = '0;
                    d_vld_next    = 1'b0;
                    run_open_next = 1'b0;
                    found_next    = 1'b0;
                    free_cnt_next = '0;
                    acc_next      = '0;
                end
            end
            fpba_pkg::ST_SCAN:
            begin
                if (issue)
                begin
                    addr_next  = addr_reg + CW'(1);
                    d_idx_next = addr_reg[IW-1:0];
                end
                d_vld_next = issue;

                if (d_vld_reg)
                begin
                    if (is_free)
                    begin
                        if (!ram_rdata)
                        begin
                            free_cnt_next = free_cnt_reg + CW'(1);
                        end
                        else if (acc_reg < KB_W'(amount_reg))
                        begin
                            ram_we        = 1'b1;
                            ram_wdata     = 1'b0;
                            acc_next      = fpba_pkg::sat_add(acc_reg, block_size_reg);
                            free_cnt_next = free_cnt_reg + CW'(1);
                        end
                    end
                    else if (!ram_rdata)
                    begin
                        free_cnt_next = free_cnt_reg + CW'(1);
                        if (run_open_reg)
                        begin
                            run_len_next = run_len_reg + CW'(1);
                            run_kb_next  = fpba_pkg::sat_add(run_kb_reg, block_size_reg);
                        end
                        else
                        begin
                            run_open_next = 1'b1;
                            run_s_next    = d_idx_reg;
                            run_len_next  = CW'(1);
                            run_kb_next   = fpba_pkg::sat_add('0, block_size_reg);
                        end
                    end
                    else if (run_open_reg)
                    begin
                        run_open_next = 1'b0;
                        if (cand_take)
                        begin
                            found_next     = 1'b1;
                            pick_next      = run_s_reg;
                            pick_len_next  = run_len_reg;
                            pick_adeq_next = (action_reg == fpba_pkg::ACT_WORST) ?
                                             cand_adeq : 1'b1;
                        end
                    end
                end
            end
            fpba_pkg::ST_CLOSE:
            begin
                run_open_next = 1'b0;
                addr_next     = '0;
                acc_next      = '0;
                if (run_open_reg && cand_take)
                begin
                    found_next     = 1'b1;
                    pick_next      = run_s_reg;
                    pick_len_next  = run_len_reg;
                    pick_adeq_next = (action_reg == fpba_pkg::ACT_WORST) ? cand_adeq : 1'b1;
                end
            end
            fpba_pkg::ST_MARK:
            begin
                if (mark_go)
                begin
                    ram_we        = 1'b1;
                    ram_waddr     = pick_reg + addr_reg[IW-1:0];
                    ram_wdata     = 1'b1;
                    addr_next     = addr_reg + CW'(1);
                    acc_next      = fpba_pkg::sat_add(acc_reg, block_size_reg);
                    free_cnt_next = free_cnt_reg - CW'(1);
                end
            end
            fpba_pkg::ST_DONE:
            begin
                if (rsp_load)
                begin
                    rsp_next.ok         = done_ok;
                    rsp_next.run_start  = (!is_free && done_ok) ? start_ext[7:0] : 8'd0;
                    rsp_next.free_count = free_ext[fpba_pkg::COUNT_W-1:0];
                    rsp_valid_next      = 1'b1;
                end
            end
            default:
            begin
                addr_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= fpba_pkg::ST_CLEAR;
            block_size_reg  <= fpba_pkg::BLOCK_SIZE_RESET;
            block_count_reg <= fpba_pkg::BLOCK_COUNT_RESET;
            addr_reg        <= '0;
            d_vld_reg       <= 1'b0;
            run_open_reg    <= 1'b0;
            found_reg       <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            d_vld_reg     <= d_vld_next;
            run_open_reg  <= run_open_next;
            found_reg     <= found_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    fpba_pkg::CFG_BLOCK_SIZE_KB: block_size_reg  <= cfg_data;
                    fpba_pkg::CFG_BLOCK_COUNT:
                        block_count_reg <= cfg_data[fpba_pkg::COUNT_W-1:0];
                    default:                     block_size_reg  <= block_size_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg    <= action_next;
        amount_reg    <= amount_next;
        d_idx_reg     <= d_idx_next;
        run_s_reg     <= run_s_next;
        run_len_reg   <= run_len_next;
        run_kb_reg    <= run_kb_next;
        pick_reg      <= pick_next;
        pick_len_reg  <= pick_len_next;
        pick_adeq_reg <= pick_adeq_next;
        free_cnt_reg  <= free_cnt_next;
        acc_reg       <= acc_next;
        rsp_reg       <= rsp_next;
    end

endmodule

// File: sv/fpba_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module fpba_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fit-policy block allocator.
// ----------------------------------------------------------------------------
// Requests are driven under random gaps while the response side stalls at
// random. A bitmap model in the bench computes the grant of every accepted
// request, and each response beat is compared with the oldest pending grant.
// Directed tests cover the reset setup, the three fit policies, the limits of
// the use range and a zero block size. Random phases with new register
// settings, a back-to-back stretch and a long response stall follow.
// ----------------------------------------------------------------------------
module tb;

    localparam int                            MAX_BLOCKS  = 256;
    localparam logic [fpba_pkg::AMOUNT_W-1:0] AMOUNT_MAX  = '1;
    localparam int                            HOLD_CYCLES = 3000;
    localparam int                            CYCLE_LIMIT = 2_000_000;
    localparam int                            PHASES      = 11;
    localparam int                            PHASE_ITEMS = 50;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           req_valid = 1'b0;
    logic                           req_ready;
    fpba_pkg::req_t                 req       = '0;
    logic                           rsp_valid;
    logic                           rsp_ready = 1'b0;
    fpba_pkg::rsp_t                 rsp;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [fpba_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [fpba_pkg::SIZE_W-1:0]    cfg_data  = '0;

    bit                             blk_used [MAX_BLOCKS];
    logic [fpba_pkg::SIZE_W-1:0]    blk_size  = fpba_pkg::BLOCK_SIZE_RESET;
    logic [fpba_pkg::COUNT_W-1:0]   blk_count = fpba_pkg::BLOCK_COUNT_RESET;
    fpba_pkg::rsp_t                 pending_grants [$];

    int                             errors      = 0;
    int                             cycles      = 0;
    bit                             quiet       = 1'b0;
    int                             hold_reqs   = 0;
    int                             hold_served = 0;
    int                             hold_left   = 0;
    int                             stall_left  = 0;

    fit_policy_block_allocator #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("fit_policy_block_allocator verification failed");
            $finish;
        end
    end

    function automatic bit fits(input int unsigned len,
                                input logic [fpba_pkg::AMOUNT_W-1:0] amt);
        longint unsigned total;
        total = longint'(len) * longint'(blk_size);
        return total >= amt;
    endfunction

    function automatic int unsigned use_span();
        return (blk_count > MAX_BLOCKS) ? MAX_BLOCKS : blk_count;
    endfunction

    function automatic fpba_pkg::rsp_t grant_for(input fpba_pkg::action_t act,
                                                 input logic [fpba_pkg::AMOUNT_W-1:0] amt);
        int unsigned     span;
        int unsigned     i;
        int unsigned     s;
        int unsigned     k;
        int unsigned     run_len;
        int unsigned     pick;
        int unsigned     pick_len;
        longint unsigned freed;
        longint unsigned need;
        longint unsigned free_blocks;
        bit              found;
        fpba_pkg::rsp_t  g;
        span     = use_span();
        found    = 1'b0;
        pick     = 0;
        pick_len = 0;
        freed    = 0;
        g        = '0;
        if (act == fpba_pkg::ACT_FREE)
        begin
            for (i = 0; i < span && freed < amt; i++)
            begin
                if (blk_used[i])
                begin
                    blk_used[i] = 1'b0;
                    freed += blk_size;
                end
            end
            g.ok = (freed >= amt);
        end
        else
        begin
            i = 0;
            while (i < span)
            begin
                if (blk_used[i])
                begin
                    i++;
                end
                else
                begin
                    s = i;
                    while (i < span && !blk_used[i])
                    begin
                        i++;
                    end
                    run_len = i - s;
                    case (act)
                        fpba_pkg::ACT_FIRST:
                        begin
                            if (!found && fits(run_len, amt))
                            begin
                                found    = 1'b1;
                                pick     = s;
                                pick_len = run_len;
                            end
                        end
                        fpba_pkg::ACT_BEST:
                        begin
                            if (fits(run_len, amt) && (!found || run_len < pick_len))
                            begin
                                found    = 1'b1;
                                pick     = s;
                                pick_len = run_len;
                            end
                        end
                        default:
                        begin
                            if (!found || run_len > pick_len)
                            begin
                                found    = 1'b1;
                                pick     = s;
                                pick_len = run_len;
                            end
                        end
                    endcase
                end
            end
            if (found && act == fpba_pkg::ACT_WORST && !fits(pick_len, amt))
            begin
                found = 1'b0;
            end
            if (found)
            begin
                need = (blk_size == 0) ? 0 : (amt + blk_size - 1) / blk_size;
                for (k = 0; k < need && k < pick_len; k++)
                begin
                    blk_used[pick + k] = 1'b1;
                end
                g.ok        = 1'b1;
                g.run_start = pick[7:0];
            end
        end
        free_blocks = 0;
        for (i = 0; i < span; i++)
        begin
            if (!blk_used[i])
            begin
                free_blocks++;
            end
        end
        g.free_count = free_blocks[fpba_pkg::COUNT_W-1:0];
        return g;
    endfunction

    // Hold-off requests from the tests override the random stalls.
    always @(posedge clk)
    begin
        if (hold_reqs != hold_served)
        begin
            hold_served = hold_reqs;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 99) < 20)
            begin
                stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 90)
                                                           : $urandom_range(1, 3);
            end
        end
    end

    always @(posedge clk)
    begin : check_grants
        fpba_pkg::rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_grants.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat, expected none, actual %p", $time, rsp);
            end
            else
            begin
                want = pending_grants.pop_front();
                if (rsp.ok !== want.ok)
                begin
                    errors++;
                    $display("%0t: ok expected %0d actual %0d", $time, want.ok, rsp.ok);
                end
                if (rsp.run_start !== want.run_start)
                begin
                    errors++;
                    $display("%0t: run_start expected %0d actual %0d",
                             $time, want.run_start, rsp.run_start);
                end
                if (rsp.free_count !== want.free_count)
                begin
                    errors++;
                    $display("%0t: free_count expected %0d actual %0d",
                             $time, want.free_count, rsp.free_count);
                end
            end
        end
    end

    task automatic issue_request(input fpba_pkg::action_t act,
                                 input logic [fpba_pkg::AMOUNT_W-1:0] amt);
        int unsigned gap;
        int unsigned r;
        req_valid <= 1'b1;
        req       <= '{action: act, amount_kb: amt};
        do
            @(posedge clk);
        while (!req_ready);
        pending_grants.push_back(grant_for(act, amt));
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            gap = 0;
        else if (r < 90)
            gap = $urandom_range(1, 3);
        else if (r < 98)
            gap = $urandom_range(4, 12);
        else
            gap = $urandom_range(20, 60);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_grants.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [fpba_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fpba_pkg::SIZE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == fpba_pkg::CFG_BLOCK_SIZE_KB)
            blk_size = data;
        else
            blk_count = data[fpba_pkg::COUNT_W-1:0];
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_request();
        int unsigned       span;
        int unsigned       lim;
        int unsigned       r;
        longint unsigned   amt;
        fpba_pkg::action_t act;
        span = use_span();
        r    = $urandom_range(0, 99);
        act  = (r < 30) ? fpba_pkg::ACT_FREE : fpba_pkg::action_t'($urandom_range(0, 2));
        r    = $urandom_range(0, 99);
        if (r < 8)
        begin
            amt = 0;
        end
        else if (r < 18)
        begin
            amt = $urandom_range(0, AMOUNT_MAX);
        end
        else
        begin
            lim = ($urandom_range(0, 2) != 0) ? (span + 3) / 4 : span;
            if (lim == 0)
                lim = 1;
            amt = longint'($urandom_range(1, lim)) * blk_size;
            if (blk_size > 1)
                amt -= $urandom_range(0, blk_size - 1);
            if (amt > AMOUNT_MAX)
                amt = AMOUNT_MAX;
        end
        issue_request(act, amt[fpba_pkg::AMOUNT_W-1:0]);
    endtask

    task automatic test_reset_defaults();
        issue_request(fpba_pkg::ACT_FIRST, 1);
        issue_request(fpba_pkg::ACT_BEST, 5);
        issue_request(fpba_pkg::ACT_WORST, AMOUNT_MAX);
        issue_request(fpba_pkg::ACT_FIRST, 0);
        issue_request(fpba_pkg::ACT_FREE, 0);
        issue_request(fpba_pkg::ACT_FREE, AMOUNT_MAX);
        wait_idle();
    endtask

    task automatic test_fit_policies();
        write_reg(fpba_pkg::CFG_BLOCK_SIZE_KB, 1);
        write_reg(fpba_pkg::CFG_BLOCK_COUNT, 16);
        issue_request(fpba_pkg::ACT_FIRST, 10);
        issue_request(fpba_pkg::ACT_FREE, 4);
        issue_request(fpba_pkg::ACT_BEST, 3);
        issue_request(fpba_pkg::ACT_WORST, 3);
        issue_request(fpba_pkg::ACT_FIRST, 5);
        issue_request(fpba_pkg::ACT_BEST, 1);
        issue_request(fpba_pkg::ACT_FIRST, 1);
        wait_idle();
    endtask

    task automatic test_use_range();
        write_reg(fpba_pkg::CFG_BLOCK_COUNT, 0);
        issue_request(fpba_pkg::ACT_FIRST, 1);
        issue_request(fpba_pkg::ACT_FREE, 0);
        issue_request(fpba_pkg::ACT_FREE, 1);
        wait_idle();
        write_reg(fpba_pkg::CFG_BLOCK_COUNT, 511);
        write_reg(fpba_pkg::CFG_BLOCK_SIZE_KB, 2);
        issue_request(fpba_pkg::ACT_FIRST, 300);
        wait_idle();
        write_reg(fpba_pkg::CFG_BLOCK_COUNT, 1);
        issue_request(fpba_pkg::ACT_FIRST, 1);
        issue_request(fpba_pkg::ACT_BEST, 1);
        issue_request(fpba_pkg::ACT_FREE, 2);
        wait_idle();
        write_reg(fpba_pkg::CFG_BLOCK_COUNT, 256);
        write_reg(fpba_pkg::CFG_BLOCK_SIZE_KB, 65535);
        issue_request(fpba_pkg::ACT_WORST, AMOUNT_MAX);
        issue_request(fpba_pkg::ACT_FREE, 1);
        wait_idle();
    endtask

    task automatic test_zero_block_size();
        write_reg(fpba_pkg::CFG_BLOCK_SIZE_KB, 0);
        write_reg(fpba_pkg::CFG_BLOCK_COUNT, 8);
        issue_request(fpba_pkg::ACT_FIRST, 0);
        issue_request(fpba_pkg::ACT_BEST, 5);
        issue_request(fpba_pkg::ACT_WORST, 0);
        issue_request(fpba_pkg::ACT_FREE, 7);
        issue_request(fpba_pkg::ACT_FREE, 0);
        wait_idle();
    endtask

    task automatic test_random_phases();
        int unsigned r;
        int unsigned size_kb;
        int unsigned count;
        for (int p = 0; p < PHASES; p++)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                size_kb = $urandom_range(1, 4);
            else if (r < 70)
                size_kb = $urandom_range(5, 64);
            else if (r < 80)
                size_kb = $urandom_range(65, 65535);
            else if (r < 88)
                size_kb = 65535;
            else if (r < 94)
                size_kb = 0;
            else
                size_kb = $urandom_range(0, 65535);
            r = $urandom_range(0, 99);
            if (r < 60)
                count = $urandom_range(1, 24);
            else if (r < 75)
                count = $urandom_range(25, 256);
            else if (r < 82)
                count = 256;
            else if (r < 87)
                count = 0;
            else if (r < 92)
                count = $urandom_range(257, 511);
            else
                count = $urandom_range(0, 65535);
            write_reg(fpba_pkg::CFG_BLOCK_SIZE_KB, size_kb[fpba_pkg::SIZE_W-1:0]);
            write_reg(fpba_pkg::CFG_BLOCK_COUNT, count[fpba_pkg::SIZE_W-1:0]);
            repeat (PHASE_ITEMS) random_request();
            wait_idle();
        end
    endtask

    task automatic test_back_to_back();
        write_reg(fpba_pkg::CFG_BLOCK_SIZE_KB, 3);
        write_reg(fpba_pkg::CFG_BLOCK_COUNT, 12);
        quiet = 1'b1;
        repeat (25) random_request();
        wait_idle();
        quiet = 1'b0;
    endtask

    task automatic test_response_hold();
        write_reg(fpba_pkg::CFG_BLOCK_SIZE_KB, 4);
        write_reg(fpba_pkg::CFG_BLOCK_COUNT, 32);
        quiet = 1'b1;
        hold_reqs++;
        repeat (10) random_request();
        wait_idle();
        quiet = 1'b0;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_fit_policies();
        test_use_range();
        test_zero_block_size();
        test_back_to_back();
        test_response_hold();
        test_random_phases();
        wait_idle();
        repeat (2 * MAX_BLOCKS + 16) @(posedge clk);
        if (pending_grants.size() != 0)
        begin
            errors++;
            $display("%0t: grants left, expected 0 actual %0d", $time, pending_grants.size());
        end
        if (errors == 0)
            $display("fit_policy_block_allocator verification clean");
        else
            $display("fit_policy_block_allocator verification failed");
        $finish;
    end

endmodule

// File: filelist.f
sv/fpba_pkg.sv
sv/fpba_ram.sv
sv/fit_policy_block_allocator.sv
test/tb.sv
